// ===== sv/dog_pkg.sv =====
package dog_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RADIUS     = 3;
    localparam int TAPS       = 2 * RADIUS + 1;
    localparam int COEF_BITS  = 14;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COEF_REG_W = 56;
    localparam int CFG_W      = 56;
    localparam int CFG_IDX_W  = 2;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT + TAPS);
    localparam int SEL_W  = $clog2(TAPS);
    localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ICW    = $clog2(MAX_WIDTH * MAX_HEIGHT + RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int PW     = PIX_W + COEF_BITS;
    localparam int VW     = PW + $clog2(TAPS);
    localparam int HPW    = VW + COEF_BITS;
    localparam int HW     = HPW + $clog2(TAPS);
    localparam int SHIFT  = 2 * COEF_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_WIDE_COEF,
        CFG_NARROW_COEF
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        logic [SEL_W-1:0]      wbank;
        logic [XW-1:0]         addr;
        logic [PIX_W-1:0]      wdata;
        logic                  re;
    } t_mem_req;

    typedef struct packed {
        logic                         prod;
        logic                         last;
        logic [PIX_W-1:0]             fwd_pix;
        logic [TAPS-1:0]              isfwd;
        logic [TAPS-1:0][SEL_W-1:0]   bank;
        logic [TAPS-1:0][SEL_W-1:0]   hsel;
    } t_rd_meta;

    typedef struct packed {
        logic                         prod;
        logic                         last;
        logic [TAPS-1:0][SEL_W-1:0]   hsel;
        logic [VW-1:0]                vw;
        logic [VW-1:0]                vn;
    } t_col;

    function automatic logic [COEF_BITS-1:0] coef_at(input logic [COEF_REG_W-1:0] r,
                                                     input int d);
        logic [COEF_BITS-1:0] c;
        c = '0;
        if (COEF_BITS * (d + 1) <= COEF_REG_W) begin
            c = r[COEF_BITS*d +: COEF_BITS];
        end
        return c;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(mx)) begin
            r = DIM_W'(mx);
        end
        return r;
    endfunction

endpackage

// ===== sv/dog_edge_detector.sv =====
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+------------------------------------------------
// pixel in | in  | i_valid / o_stall  | i_pixel, i_fill
// result   | out | o_valid / i_stall  | o_edge_value, o_blur_wide, o_blur_narrow,
//          |     |                    | o_last_of_frame
// config   | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One request per clock while the result side does not stall. A request is taken whenever
// the result register is empty or being drained.
// Reset (synchronous, active low) clears counters and valid bits and sets the config
// registers to defaults; line banks are not cleared and hold stale rows until written.
// A stalled result freezes the whole pipe, so o_stall follows i_stall then.
module dog_edge_detector import dog_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_fill,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_edge_value,
    output logic [PIX_W-1:0]     o_blur_wide,
    output logic [PIX_W-1:0]     o_blur_narrow,
    output logic                 o_last_of_frame,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Structure:
    //  - seven line banks, one per image row modulo seven, each a full line deep. Every
    //    request reads the same column from all banks, giving one vertical column of the
    //    window per request; in-frame ones also write their pixel into their row's bank.
    //  - ctrl keeps the frame counters and works out, per tap, which bank holds the
    //    clamped row (border replication) and which history slot holds the clamped
    //    column. The row being written is forwarded instead of read.
    //  - vert: column pixels times the 1-D coefficients, then a vertical sum (two stages).
    //  - horz: seven-deep history of vertical sums, horizontal multiply, sum,
    //    truncate, clamp and compare, then the result register.

    logic [DIM_W-1:0]      r_line_width, r_frame_height;
    logic [COEF_REG_W-1:0] r_wide_coef, r_narrow_coef;

    logic                        en;
    t_mem_req                    mem;
    logic                        meta_v;
    t_rd_meta                    meta;
    logic [TAPS-1:0][PIX_W-1:0]  rdata;
    logic                        col_v;
    t_col                        col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= DIM_W'(MAX_WIDTH);
            r_frame_height <= DIM_W'(MAX_HEIGHT);
            r_wide_coef    <= '0;
            r_narrow_coef  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_WIDE_COEF:    r_wide_coef    <= i_cfg_data[COEF_REG_W-1:0];
                CFG_NARROW_COEF:  r_narrow_coef  <= i_cfg_data[COEF_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dog_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_pixel  (i_pixel),
        .i_fill   (i_fill),
        .i_width  (r_line_width),
        .i_height (r_frame_height),
        .o_mem    (mem),
        .o_meta_v (meta_v),
        .o_meta   (meta)
    );

    for (genvar g = 0; g < TAPS; g++) begin : g_bank
        dog_ram #(
            .DEPTH (MAX_WIDTH),
            .DW    (PIX_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (mem.we && (mem.wbank == SEL_W'(g))),
            .i_waddr (mem.addr),
            .i_wdata (mem.wdata),
            .i_re    (mem.re),
            .i_raddr (mem.addr),
            .o_rdata (rdata[g])
        );
    end

    dog_vert u_vert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_meta_v (meta_v),
        .i_meta   (meta),
        .i_rdata  (rdata),
        .i_wide   (r_wide_coef),
        .i_narrow (r_narrow_coef),
        .o_col_v  (col_v),
        .o_col    (col)
    );

    dog_horz u_horz (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_col_v         (col_v),
        .i_col           (col),
        .i_wide          (r_wide_coef),
        .i_narrow        (r_narrow_coef),
        .i_stall         (i_stall),
        .o_en            (en),
        .o_valid         (o_valid),
        .o_edge_value    (o_edge_value),
        .o_blur_wide     (o_blur_wide),
        .o_blur_narrow   (o_blur_narrow),
        .o_last_of_frame (o_last_of_frame)
    );

    assign o_stall = !en;

endmodule

// ===== sv/dog_ram.sv =====
module dog_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dog_ctrl.sv =====
module dog_ctrl import dog_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_fill,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output t_mem_req         o_mem,
    output logic             o_meta_v,
    output t_rd_meta         o_meta
);

    localparam logic [DIM_W:0] K_R   = (DIM_W+1)'(RADIUS);
    localparam logic [DIM_W:0] K_MAX = (DIM_W+1)'(TAPS - 1);

    logic [ICW-1:0]   r_in_cnt;
    logic [NW-1:0]    r_out_cnt;
    logic [XW-1:0]    r_x_in;
    logic [YW-1:0]    r_y_in;
    logic [SEL_W-1:0] r_b_in;
    logic [XW-1:0]    r_x_out;
    logic             r_meta_v;
    t_rd_meta         r_meta;

    logic [DIM_W-1:0] w, h;
    logic [NW-1:0]    n;
    logic [ICW-1:0]   delay;
    logic             acc, clr, in_frame, prod, last;
    logic [ICW-1:0]   cur_i;
    logic [NW-1:0]    cur_k;
    logic [XW-1:0]    cur_xi, cur_xo;
    logic [YW-1:0]    cur_yi;
    logic [SEL_W-1:0] cur_b;
    logic [YW:0]      yi_e, hm1_e, row_off;
    logic [SEL_W:0]   bt;
    logic [DIM_W:0]   xo_e, w_e, hi, lo, m0;
    logic [TAPS-1:0][SEL_W-1:0] d, bank, hsel;
    logic [TAPS-1:0]  isfwd;

    always_comb begin
        w     = clamp_dim(i_width, MAX_WIDTH);
        h     = clamp_dim(i_height, MAX_HEIGHT);
        n     = NW'(w) * NW'(h);
        delay = ICW'(RADIUS) * ICW'(w) + ICW'(RADIUS);
        acc   = i_valid && i_en;
        clr   = r_out_cnt >= n;

        cur_i  = clr ? '0 : r_in_cnt;
        cur_k  = clr ? '0 : r_out_cnt;
        cur_xi = clr ? '0 : r_x_in;
        cur_yi = clr ? '0 : r_y_in;
        cur_b  = clr ? '0 : r_b_in;
        cur_xo = clr ? '0 : r_x_out;

        in_frame = cur_i < ICW'(n);
        prod     = cur_i >= delay;
        last     = cur_k == n - NW'(1);

        // row of each vertical tap, clamped to the frame, as a distance back from the write row
        yi_e  = (YW+1)'(cur_yi);
        hm1_e = (YW+1)'(h) - (YW+1)'(1);
        for (int t = 0; t < TAPS; t++) begin
            row_off = (YW+1)'(TAPS - 1 - t);
            if (yi_e < row_off) begin
                d[t] = SEL_W'(cur_yi);
            end else if (yi_e > hm1_e + row_off) begin
                d[t] = SEL_W'(yi_e - hm1_e);
            end else begin
                d[t] = SEL_W'(row_off);
            end
            isfwd[t] = d[t] == '0;
            bt = (SEL_W+1)'(cur_b) + (SEL_W+1)'(TAPS) - (SEL_W+1)'(d[t]);
            if (bt >= (SEL_W+1)'(TAPS)) begin
                bt = bt - (SEL_W+1)'(TAPS);
            end
            bank[t] = SEL_W'(bt);
        end

        // column history slot per horizontal tap, clamped to the current line
        xo_e = (DIM_W+1)'(cur_xo);
        w_e  = (DIM_W+1)'(w);
        hi   = (xo_e + K_R > K_MAX) ? K_MAX : xo_e + K_R;
        lo   = (xo_e + K_R + 1'b1 > w_e) ? xo_e + K_R + 1'b1 - w_e : '0;
        for (int j = 0; j < TAPS; j++) begin
            m0 = (DIM_W+1)'(TAPS - 1 - j);
            if (m0 > hi) begin
                hsel[j] = SEL_W'(hi);
            end else if (m0 < lo) begin
                hsel[j] = SEL_W'(lo);
            end else begin
                hsel[j] = SEL_W'(m0);
            end
        end

        o_mem.we    = acc && in_frame;
        o_mem.wbank = cur_b;
        o_mem.addr  = cur_xi;
        o_mem.wdata = i_fill ? '0 : i_pixel;
        o_mem.re    = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_x_in    <= '0;
            r_y_in    <= '0;
            r_b_in    <= '0;
            r_x_out   <= '0;
            r_meta_v  <= 1'b0;
        end else begin
            if (i_en) begin
                r_meta_v <= acc;
            end
            if (acc) begin
                if (prod && last) begin
                    r_in_cnt  <= '0;
                    r_out_cnt <= '0;
                    r_x_in    <= '0;
                    r_y_in    <= '0;
                    r_b_in    <= '0;
                    r_x_out   <= '0;
                end else begin
                    r_in_cnt <= cur_i + ICW'(1);
                    if ((DIM_W+1)'(cur_xi) + 1'b1 == (DIM_W+1)'(w)) begin
                        r_x_in <= '0;
                        r_y_in <= cur_yi + YW'(1);
                        r_b_in <= (cur_b == SEL_W'(TAPS - 1)) ? '0 : cur_b + SEL_W'(1);
                    end else begin
                        r_x_in <= cur_xi + XW'(1);
                        r_y_in <= cur_yi;
                        r_b_in <= cur_b;
                    end
                    if (prod) begin
                        r_out_cnt <= cur_k + NW'(1);
                        r_x_out   <= ((DIM_W+1)'(cur_xo) + 1'b1 == (DIM_W+1)'(w)) ?
                                     '0 : cur_xo + XW'(1);
                    end else begin
                        r_out_cnt <= cur_k;
                        r_x_out   <= cur_xo;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_meta.prod    <= prod;
            r_meta.last    <= last;
            r_meta.fwd_pix <= o_mem.wdata;
            r_meta.isfwd   <= isfwd;
            r_meta.bank    <= bank;
            r_meta.hsel    <= hsel;
        end
    end

    assign o_meta_v = r_meta_v;
    assign o_meta   = r_meta;

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && prod && last |=> r_in_cnt == '0 && r_out_cnt == '0)
        else $error("counters not cleared after frame end");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !clr && !prod |=> r_out_cnt == $past(r_out_cnt))
        else $error("output count moved without a result");

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_in < SEL_W'(TAPS))
        else $error("line bank pointer out of range");

endmodule

// ===== sv/dog_vert.sv =====
module dog_vert import dog_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_meta_v,
    input  t_rd_meta                    i_meta,
    input  logic [TAPS-1:0][PIX_W-1:0]  i_rdata,
    input  logic [COEF_REG_W-1:0]       i_wide,
    input  logic [COEF_REG_W-1:0]       i_narrow,
    output logic                        o_col_v,
    output t_col                        o_col
);

    logic [TAPS-1:0][PIX_W-1:0]     p;
    logic [TAPS-1:0][COEF_BITS-1:0] cw, cn;
    logic [TAPS-1:0][PW-1:0]        r_pw, r_pn;
    logic                           r_a_v, r_a_prod, r_a_last;
    logic [TAPS-1:0][SEL_W-1:0]     r_a_hsel;
    logic [VW-1:0]                  sw, sn;
    logic                           r_col_v;
    t_col                           r_col;

    for (genvar t = 0; t < TAPS; t++) begin : g_tap
        assign cw[t] = coef_at(i_wide,   (t < RADIUS) ? RADIUS - t : t - RADIUS);
        assign cn[t] = coef_at(i_narrow, (t < RADIUS) ? RADIUS - t : t - RADIUS);
        // the row being written this item comes straight from the input
        assign p[t]  = i_meta.isfwd[t] ? i_meta.fwd_pix : i_rdata[i_meta.bank[t]];
    end

    always_comb begin
        sw = '0;
        sn = '0;
        for (int t = 0; t < TAPS; t++) begin
            sw = sw + VW'(r_pw[t]);
            sn = sn + VW'(r_pn[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_col_v <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= i_meta_v;
            r_col_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < TAPS; t++) begin
                r_pw[t] <= PW'(p[t]) * PW'(cw[t]);
                r_pn[t] <= PW'(p[t]) * PW'(cn[t]);
            end
            r_a_prod  <= i_meta.prod;
            r_a_last  <= i_meta.last;
            r_a_hsel  <= i_meta.hsel;
            r_col.prod <= r_a_prod;
            r_col.last <= r_a_last;
            r_col.hsel <= r_a_hsel;
            r_col.vw   <= sw;
            r_col.vn   <= sn;
        end
    end

    assign o_col_v = r_col_v;
    assign o_col   = r_col;

endmodule

// ===== sv/dog_horz.sv =====
module dog_horz import dog_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_col_v,
    input  t_col                  i_col,
    input  logic [COEF_REG_W-1:0] i_wide,
    input  logic [COEF_REG_W-1:0] i_narrow,
    input  logic                  i_stall,
    output logic                  o_en,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_edge_value,
    output logic [PIX_W-1:0]      o_blur_wide,
    output logic [PIX_W-1:0]      o_blur_narrow,
    output logic                  o_last_of_frame
);

    logic [TAPS-1:0][VW-1:0]        r_srw, r_srn;
    logic                           r_s3_v, r_s3_last;
    logic [TAPS-1:0][SEL_W-1:0]     r_s3_hsel;
    logic [TAPS-1:0][HPW-1:0]       r_hw, r_hn;
    logic                           r_s4_v, r_s4_last;
    logic [TAPS-1:0][COEF_BITS-1:0] cw, cn;
    logic [HW-1:0]                  sw, sn, tw, tn;
    logic [PIX_W-1:0]               bw, bn;
    logic                           en;
    logic                           r_out_v, r_out_last;
    logic [PIX_W-1:0]               r_out_edge, r_out_bw, r_out_bn;

    assign en = !r_out_v || !i_stall;

    for (genvar j = 0; j < TAPS; j++) begin : g_tap
        assign cw[j] = coef_at(i_wide,   (j < RADIUS) ? RADIUS - j : j - RADIUS);
        assign cn[j] = coef_at(i_narrow, (j < RADIUS) ? RADIUS - j : j - RADIUS);
    end

    always_comb begin
        sw = '0;
        sn = '0;
        for (int j = 0; j < TAPS; j++) begin
            sw = sw + HW'(r_hw[j]);
            sn = sn + HW'(r_hn[j]);
        end
        tw = sw >> SHIFT;
        tn = sn >> SHIFT;
        bw = (tw > HW'(255)) ? 8'd255 : tw[PIX_W-1:0];
        bn = (tn > HW'(255)) ? 8'd255 : tn[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s3_v  <= i_col_v && i_col.prod;
            r_s4_v  <= r_s3_v;
            r_out_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // column history: slot 0 newest
            if (i_col_v) begin
                r_srw <= {r_srw[TAPS-2:0], i_col.vw};
                r_srn <= {r_srn[TAPS-2:0], i_col.vn};
            end
            r_s3_last <= i_col.last;
            r_s3_hsel <= i_col.hsel;
            for (int j = 0; j < TAPS; j++) begin
                r_hw[j] <= HPW'(r_srw[r_s3_hsel[j]]) * HPW'(cw[j]);
                r_hn[j] <= HPW'(r_srn[r_s3_hsel[j]]) * HPW'(cn[j]);
            end
            r_s4_last <= r_s3_last;
            if (r_s4_v) begin
                r_out_bw   <= bw;
                r_out_bn   <= bn;
                r_out_edge <= ({1'b0, bw} > {1'b0, bn} + 9'd1) ? 8'd255 : 8'd0;
                r_out_last <= r_s4_last;
            end
        end
    end

    assign o_en            = en;
    assign o_valid         = r_out_v;
    assign o_edge_value    = r_out_edge;
    assign o_blur_wide     = r_out_bw;
    assign o_blur_narrow   = r_out_bn;
    assign o_last_of_frame = r_out_last;

endmodule

// ===== dv/tb.sv =====
module tb;
    import dog_pkg::*;

    localparam int DEPTH     = TAPS * MAX_WIDTH + TAPS;
    localparam int IDLE_WAIT = 12;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [PIX_W-1:0] edge_v;
        logic [PIX_W-1:0] bw;
        logic [PIX_W-1:0] bn;
        logic             last;
    } t_pix_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_pixel;
    logic                 i_fill;
    logic                 o_valid;
    logic                 i_stall;
    logic [PIX_W-1:0]     o_edge_value;
    logic [PIX_W-1:0]     o_blur_wide;
    logic [PIX_W-1:0]     o_blur_narrow;
    logic                 o_last_of_frame;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    dog_edge_detector DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .i_fill          (i_fill),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_edge_value    (o_edge_value),
        .o_blur_wide     (o_blur_wide),
        .o_blur_narrow   (o_blur_narrow),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // shadow of the block: registers, pixel store, frame counters
    logic [DIM_W-1:0]      sh_width;
    logic [DIM_W-1:0]      sh_height;
    logic [COEF_REG_W-1:0] sh_wide;
    logic [COEF_REG_W-1:0] sh_narrow;
    logic [PIX_W-1:0]      pix_mem [DEPTH];
    int unsigned           in_cnt;
    int unsigned           out_cnt;

    t_pix_result result_q[$];
    int          errors;
    int          n_sent;
    int          n_results;
    int          n_edges;
    int          n_frames;
    int          wdog;
    bit          quiet;      // no idling on either side
    bit          hold_req;   // ask the result side for a long hold-off

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [DIM_W-1:0] v, int mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return int'(v);
    endfunction

    // 7x7 replicated-border blur, truncated and clamped
    function automatic logic [PIX_W-1:0] gauss_blur(logic [COEF_REG_W-1:0] cr,
                                                    int y, int x, int w, int h);
        longint unsigned c [RADIUS+1];
        longint unsigned acc;
        int rr;
        int cc;
        acc = 0;
        for (int d = 0; d <= RADIUS; d++) begin
            c[d] = (COEF_BITS * (d + 1) <= COEF_REG_W) ? cr[COEF_BITS*d +: COEF_BITS] : 0;
        end
        for (int dr = -RADIUS; dr <= RADIUS; dr++) begin
            rr = y + dr;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            for (int dc = -RADIUS; dc <= RADIUS; dc++) begin
                cc = x + dc;
                if (cc < 0) cc = 0;
                if (cc > w - 1) cc = w - 1;
                acc += longint'(pix_mem[(rr * w + cc) % DEPTH]) *
                       (c[dr < 0 ? -dr : dr] * c[dc < 0 ? -dc : dc]);
            end
        end
        acc = acc >> SHIFT;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    // advance the shadow by one accepted pixel request
    task automatic predict_pixel(logic [PIX_W-1:0] pix, logic fill);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned dly;
        int unsigned i;
        int unsigned k;
        t_pix_result r;
        w   = eff_dim(sh_width, MAX_WIDTH);
        h   = eff_dim(sh_height, MAX_HEIGHT);
        n   = w * h;
        dly = RADIUS * w + RADIUS;
        if (out_cnt >= n) begin
            in_cnt  = 0;
            out_cnt = 0;
        end
        i = in_cnt;
        if (i < n) pix_mem[i % DEPTH] = fill ? 8'd0 : pix;
        in_cnt = (i + 1) & 32'h1F_FFFF;
        if (i >= dly) begin
            k      = out_cnt;
            r.bw   = gauss_blur(sh_wide, k / w, k % w, w, h);
            r.bn   = gauss_blur(sh_narrow, k / w, k % w, w, h);
            r.edge_v = (r.bw > r.bn + 1) ? 8'd255 : 8'd0;
            r.last = (k == n - 1);
            result_q.push_back(r);
            if (r.last) begin
                in_cnt  = 0;
                out_cnt = 0;
            end else begin
                out_cnt = (k + 1) & 32'hF_FFFF;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one request and hold it until taken
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic fill);
        int g;
        i_valid <= 1'b1;
        i_pixel <= pix;
        i_fill  <= fill;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_pixel(pix, fill);
        n_sent++;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        wait_idle();
        i_valid    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH:   sh_width  = data[DIM_W-1:0];
            CFG_FRAME_HEIGHT: sh_height = data[DIM_W-1:0];
            CFG_WIDE_COEF:    sh_wide   = data[COEF_REG_W-1:0];
            CFG_NARROW_COEF:  sh_narrow = data[COEF_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(int w, int h,
                         logic [COEF_REG_W-1:0] cw, logic [COEF_REG_W-1:0] cn);
        write_reg(CFG_LINE_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(CFG_WIDE_COEF, CFG_W'(cw));
        write_reg(CFG_NARROW_COEF, CFG_W'(cn));
    endtask

    // one whole frame plus the flush requests behind it
    // mode 0: random pixels, 1: blocky image, 2: constant value
    task automatic send_frame(int mode, int fill_pct, logic [PIX_W-1:0] level);
        int w;
        int h;
        int n;
        logic [PIX_W-1:0] p;
        w = eff_dim(sh_width, MAX_WIDTH);
        h = eff_dim(sh_height, MAX_HEIGHT);
        n = w * h;
        for (int i = 0; i < n + RADIUS * w + RADIUS; i++) begin
            case (mode)
                0:       p = PIX_W'($urandom_range(0, 255));
                1:       p = (((i % w) / 3 + (i / w) / 2) % 2) ? level : ~level;
                default: p = level;
            endcase
            // after the frame every request is a flush, whatever it carries
            send_pixel(p, ($urandom_range(0, 99) < fill_pct) ? 1'b1 : 1'b0);
        end
        n_frames++;
    endtask

    function automatic logic [COEF_REG_W-1:0] pack_coef(int c0, int c1, int c2, int c3);
        return {COEF_BITS'(c3), COEF_BITS'(c2), COEF_BITS'(c1), COEF_BITS'(c0)};
    endfunction

    function automatic logic [COEF_REG_W-1:0] rand_coef(bit wide);
        logic [COEF_REG_W-1:0] v;
        int s;
        if ($urandom_range(0, 5) == 0) begin
            v = COEF_REG_W'({$urandom(), $urandom()});
            return v;
        end
        s = $urandom_range(1, 4);
        if (wide) begin
            return pack_coef($urandom_range(1500, 4000) / s, $urandom_range(1200, 3500) / s,
                             $urandom_range(800, 2600) / s, $urandom_range(200, 1800) / s);
        end
        return pack_coef($urandom_range(6000, 12000) / s, $urandom_range(1500, 4000) / s,
                         $urandom_range(0, 900) / s, $urandom_range(0, 60) / s);
    endfunction

    // 1x1 and 2x2 frames, all-zero and all-ones weights, fill inside the frame
    task automatic test_small_extremes();
        setup(1, 1, '1, '1);
        send_pixel(8'd255, 1'b0);
        repeat (6) send_pixel(8'd255, 1'b1);
        setup(0, 0, '0, '0);
        send_pixel(8'd0, 1'b0);
        repeat (6) send_pixel(8'h55, 1'b0);
        setup(2, 2, pack_coef(16383, 16383, 16383, 16383), pack_coef(1, 0, 0, 0));
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd255, 1'b0);
        repeat (9) send_pixel(8'h00, 1'b1);
    endtask

    // edge and no-edge through gaussian-like and flat weights
    task automatic test_edge_threshold();
        setup(9, 7, pack_coef(3000, 2800, 2300, 1700), pack_coef(9000, 4000, 700, 20));
        send_frame(1, 0, 8'd250);
        setup(5, 4, pack_coef(4096, 4096, 4096, 4096), pack_coef(4096, 4096, 4096, 4096));
        send_frame(2, 0, 8'd200);
    endtask

    // tallest frame on a one-pixel line; a height past the top clamps
    task automatic test_big_sizes();
        quiet = 1;
        setup(1, 2047, rand_coef(1'b1), rand_coef(1'b0));
        send_frame(0, 2, 8'd0);
        quiet = 0;
    endtask

    // result side holds off while requests keep coming
    task automatic test_backpressure();
        setup(16, 6, rand_coef(1'b1), rand_coef(1'b0));
        quiet    = 1;
        hold_req = 1;
        send_frame(0, 5, 8'd0);
        quiet = 0;
    endtask

    task automatic test_random_frames();
        int start;
        start = n_sent;
        while (n_sent - start < 350) begin
            setup($urandom_range(1, 14), $urandom_range(1, 10),
                  rand_coef(1'b1), rand_coef(1'b0));
            quiet = ($urandom_range(0, 4) == 0);
            send_frame($urandom_range(0, 2), $urandom_range(0, 1) ? 0 : 10,
                       PIX_W'($urandom_range(0, 255)));
        end
        quiet = 0;
    endtask

    // result side: random stalls, plus the long hold-off on request
    initial begin
        int len;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                len = $urandom_range(20, 60);
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 20);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pix_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result edge=%0d wide=%0d narrow=%0d last=%0b",
                         $time, o_edge_value, o_blur_wide, o_blur_narrow, o_last_of_frame);
                errors++;
            end else begin
                e = result_q.pop_front();
                n_results++;
                if (e.edge_v == 8'd255) n_edges++;
                if (o_edge_value !== e.edge_v) begin
                    $display("%0t: edge_value expected %0d actual %0d",
                             $time, e.edge_v, o_edge_value);
                    errors++;
                end
                if (o_blur_wide !== e.bw) begin
                    $display("%0t: blur_wide expected %0d actual %0d",
                             $time, e.bw, o_blur_wide);
                    errors++;
                end
                if (o_blur_narrow !== e.bn) begin
                    $display("%0t: blur_narrow expected %0d actual %0d",
                             $time, e.bn, o_blur_narrow);
                    errors++;
                end
                if (o_last_of_frame !== e.last) begin
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $time, e.last, o_last_of_frame);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any request or result moving
    initial begin
        wdog = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) wdog = 0;
            else wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_pixel    <= '0;
        i_fill     <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_LINE_WIDTH;
        i_cfg_data <= '0;
        errors = 0; n_sent = 0; n_results = 0; n_edges = 0; n_frames = 0;
        quiet = 0; hold_req = 0;
        sh_width = 11'd1024; sh_height = 11'd1024; sh_wide = '0; sh_narrow = '0;
        in_cnt = 0; out_cnt = 0;
        for (int i = 0; i < DEPTH; i++) pix_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_extremes();
        test_edge_threshold();
        test_backpressure();
        test_big_sizes();
        test_random_frames();

        i_valid <= 1'b0;
        wait_idle();
        if (result_q.size() != 0) errors++;
        $display("covered %0d frames, %0d requests, %0d results (%0d edges)",
                 n_frames, n_sent, n_results, n_edges);
        $display("sizes 1x1 up to 1024 lines, clamped sizes, fill, flush, long hold-off");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== dog_edge_detector.f =====
sv/dog_pkg.sv
sv/dog_ram.sv
sv/dog_ctrl.sv
sv/dog_vert.sv
sv/dog_horz.sv
sv/dog_edge_detector.sv
dv/tb.sv
